// ===== src/box_blur_zero_padded_unit_defines.svh =====
// Assertion shorthands used by the checker of the blur block.
`ifndef BOX_BLUR_ZERO_PADDED_UNIT_DEFINES_SVH
`define BOX_BLUR_ZERO_PADDED_UNIT_DEFINES_SVH

// Check a consequence in the cycle after the trigger, outside reset.
`define BBZ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check a consequence in the same cycle, reset included.
`define BBZ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/bbz_pkg.sv =====
package bbz_pkg;

	localparam int RAD_W  = 3;
	localparam int COL_W  = 12;
	localparam int ROW_W  = 16;
	localparam int PIX_W  = 8;
	localparam int IDX_W  = 2;
	localparam int DATA_W = 16;
	localparam int AREA_W = 8;
	localparam int SUM_W  = 16;
	localparam int QUO_W  = 8;

	localparam int DEF_MAX_RADIUS = 7;
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [RAD_W-1:0] RST_RADIUS = 3'd1;
	localparam logic [COL_W-1:0] RST_WIDTH  = 12'd640;
	localparam logic [ROW_W-1:0] RST_HEIGHT = 16'd480;

	// frame geometry after clamping of the registers
	typedef struct packed {
		logic [RAD_W-1:0] r;
		logic [COL_W-1:0] w;
		logic [ROW_W-1:0] h;
	} geom_t;

	// window area (2r+1)^2
	function automatic logic [AREA_W-1:0] win_area(input logic [RAD_W-1:0] r);
		logic [RAD_W:0] side;
		side = {r, 1'b1};
		return AREA_W'(side) * AREA_W'(side);
	endfunction

endpackage

// ===== src/bbz_if.sv =====
interface bbz_pix_if import bbz_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             is_padding;
	modport source (output valid, output pixel_value, output is_padding, input ready);
	modport sink   (input valid, input pixel_value, input is_padding, output ready);
endinterface

interface bbz_res_if import bbz_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] blurred_value;
	logic             last_of_frame;
	modport source (output valid, output blurred_value, output last_of_frame, input ready);
	modport sink   (input valid, input blurred_value, input last_of_frame, output ready);
endinterface

interface bbz_cfg_if import bbz_pkg::*;;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/box_blur_zero_padded_unit.sv =====
// Channel  Dir  Beat payload                     Accepted when
// pix      in   pixel_value[7:0], is_padding     pix.valid && pix.ready
// res      out  blurred_value[7:0], last_of_frame res.valid && res.ready
// cfg      in   index[1:0], data[15:0]           cfg.valid && cfg.ready
//
// Steps: a result reads the clipped window (rows x cols) in the back end, one
//   window pixel per cycle through the line store read port, then runs an
//   8-step restoring divide. The back end works on one result at a time.
// Input beats that yield no result are taken while the task queue has room.
// Reset: no clearing pass; the line store is read only where already written.
// Stalls: res back-pressure holds the back end; the front keeps taking beats
//   until the two-entry task queue fills, then drops pix.ready.
module box_blur_zero_padded_unit import bbz_pkg::*; #(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	bbz_pix_if.sink    pix,
	bbz_res_if.source  res,
	bbz_cfg_if.sink    cfg
);

	// line store holds 2*MAX_RADIUS+2 rows of MAX_WIDTH raster positions
	localparam int STORE_DEPTH = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int DLY_W       = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
	localparam int DPROD_W     = RAD_W + COL_W;

	logic [RAD_W-1:0] radius_q;
	logic [COL_W-1:0] image_width_q;
	logic [ROW_W-1:0] image_height_q;

	geom_t             geom;
	logic [DPROD_W-1:0] dprod;
	logic [DLY_W-1:0]  delay;
	logic              cfg_fire;
	logic              restart;

	logic          push, pop, q_full, q_empty;
	logic [AW-1:0] push_base, q_base;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [PIX_W-1:0] wr_data, rd_data;

	// Config is always taken; a write to a known register restarts the frame.
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign restart   = cfg_fire && ((cfg.index == REG_RADIUS) ||
	                                (cfg.index == REG_WIDTH) ||
	                                (cfg.index == REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q       <= RST_RADIUS;
			image_width_q  <= RST_WIDTH;
			image_height_q <= RST_HEIGHT;
		end else if (cfg_fire) begin
			case (cfg.index)
				REG_RADIUS: radius_q       <= cfg.data[RAD_W-1:0];
				REG_WIDTH:  image_width_q  <= cfg.data[COL_W-1:0];
				REG_HEIGHT: image_height_q <= cfg.data[ROW_W-1:0];
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// Clamp the geometry: radius saturates, width held to 1..MAX_WIDTH,
	// zero height acts as one row.
	assign geom.r = (32'(radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_q;
	assign geom.w = (image_width_q == '0) ? COL_W'(1) :
	                (32'(image_width_q) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : image_width_q;
	assign geom.h = (image_height_q == '0) ? ROW_W'(1) : image_height_q;

	// Results trail inputs by r rows plus r pixels.
	assign dprod = DPROD_W'(geom.r) * DPROD_W'(geom.w) + DPROD_W'(geom.r);
	assign delay = DLY_W'(dprod);

	bbz_front #(
		.STORE_DEPTH (STORE_DEPTH),
		.DLY_W       (DLY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.geom      (geom),
		.delay     (delay),
		.pix       (pix),
		.q_full    (q_full),
		.push      (push),
		.push_base (push_base),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Each queued task is the store address of the newest pixel at its issue.
	bbz_fifo #(
		.WIDTH (AW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (restart),
		.push   (push),
		.wdata  (push_base),
		.pop    (pop),
		.rdata  (q_base),
		.full   (q_full),
		.empty  (q_empty)
	);

	bbz_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bbz_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.geom    (geom),
		.q_empty (q_empty),
		.q_base  (q_base),
		.pop     (pop),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (res)
	);

endmodule

// ===== src/bbz_ram.sv =====
module bbz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/bbz_fifo.sv =====
module bbz_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             flush,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== src/bbz_front.sv =====
module bbz_front import bbz_pkg::*; #(
	parameter int STORE_DEPTH = 32768,
	parameter int DLY_W       = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           restart,
	input  geom_t                          geom,
	input  logic [DLY_W-1:0]               delay,
	bbz_pix_if.sink                        pix,
	input  logic                           q_full,
	output logic                           push,
	output logic [$clog2(STORE_DEPTH)-1:0] push_base,
	output logic                           wr_en,
	output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
	output logic [PIX_W-1:0]               wr_data
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic [AW-1:0]    ptr_q;
	logic [DLY_W-1:0] cnt_q;
	logic             full_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] t_col_q;
	logic [ROW_W-1:0] t_row_q;

	logic accept, adv, started, in_last, task_last;

	assign pix.ready = !q_full;
	assign accept    = pix.valid && pix.ready;
	// padding before the frame is complete is swallowed without effect
	assign adv       = accept && !(pix.is_padding && !full_q);
	assign started   = (cnt_q == delay);
	assign in_last   = (in_row_q == geom.h - 1'b1) && (in_col_q == geom.w - 1'b1);
	assign task_last = (t_row_q == geom.h - 1'b1) && (t_col_q == geom.w - 1'b1);

	assign wr_en     = adv && !full_q;
	assign wr_addr   = ptr_q;
	assign wr_data   = pix.pixel_value;
	assign push      = adv && started;
	assign push_base = ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			cnt_q    <= '0;
			full_q   <= 1'b0;
			in_col_q <= '0;
			in_row_q <= '0;
			t_col_q  <= '0;
			t_row_q  <= '0;
		end else if (restart) begin
			cnt_q    <= '0;
			full_q   <= 1'b0;
			in_col_q <= '0;
			in_row_q <= '0;
			t_col_q  <= '0;
			t_row_q  <= '0;
		end else if (adv) begin
			ptr_q <= (ptr_q == AW'(STORE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
			if (!full_q) begin
				if (in_last) begin
					full_q   <= 1'b1;
					in_col_q <= '0;
					in_row_q <= '0;
				end else if (in_col_q == geom.w - 1'b1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (!started) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (task_last) begin
				// frame done: start the next one from its first pixel
				cnt_q    <= '0;
				full_q   <= 1'b0;
				in_col_q <= '0;
				in_row_q <= '0;
				t_col_q  <= '0;
				t_row_q  <= '0;
			end else if (t_col_q == geom.w - 1'b1) begin
				t_col_q <= '0;
				t_row_q <= t_row_q + 1'b1;
			end else begin
				t_col_q <= t_col_q + 1'b1;
			end
		end
	end

endmodule

// ===== src/bbz_back.sv =====
module bbz_back import bbz_pkg::*; #(
	parameter int STORE_DEPTH = 32768
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           restart,
	input  geom_t                          geom,
	input  logic                           q_empty,
	input  logic [$clog2(STORE_DEPTH)-1:0] q_base,
	output logic                           pop,
	output logic                           rd_en,
	output logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
	input  logic [PIX_W-1:0]               rd_data,
	bbz_res_if.source                      res
);

	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int OFF_W  = RAD_W + 1;
	localparam int PROD_W = OFF_W + COL_W;
	localparam int DIV_W  = $clog2(QUO_W);

	typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_READ, ST_WAIT, ST_DIV, ST_OUT} state_t;

	state_t           state_q;
	logic [AW-1:0]    base_q;
	logic [SUM_W-1:0] sum_q;
	logic [QUO_W-1:0] quo_q;
	logic [DIV_W-1:0] div_i_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic             last_q;
	logic [ROW_W-1:0] cy_q;
	logic [ROW_W-1:0] y1_q;
	logic [COL_W-1:0] cx_q;
	logic [COL_W-1:0] x0_q;
	logic [COL_W-1:0] x1_q;
	logic [OFF_W-1:0] row_off_q;
	logic [OFF_W-1:0] col_off_q;
	logic [AW-1:0]    dist_q;
	logic [AW-1:0]    row_dist_q;
	logic             rd_v_q;

	logic [RAD_W-1:0]  ry, rx;
	logic [ROW_W:0]    row_hi;
	logic [COL_W:0]    col_hi;
	logic [ROW_W-1:0]  y1_n;
	logic [COL_W-1:0]  x1_n;
	logic [AREA_W-1:0] area;
	logic [SUM_W-1:0]  shifted;
	logic [PROD_W-1:0] prod;
	logic [AW:0]       diff;
	logic [AW-1:0]     next_row_dist;

	// clipped window bounds around the current result position
	assign ry = (out_row_q < ROW_W'(geom.r)) ? out_row_q[RAD_W-1:0] : geom.r;
	assign rx = (out_col_q < COL_W'(geom.r)) ? out_col_q[RAD_W-1:0] : geom.r;
	assign row_hi = {1'b0, out_row_q} + (ROW_W + 1)'(geom.r);
	assign col_hi = {1'b0, out_col_q} + (COL_W + 1)'(geom.r);
	assign y1_n = (row_hi > {1'b0, geom.h - 1'b1}) ? geom.h - 1'b1 : row_hi[ROW_W-1:0];
	assign x1_n = (col_hi > {1'b0, geom.w - 1'b1}) ? geom.w - 1'b1 : col_hi[COL_W-1:0];

	assign area    = win_area(geom.r);
	assign shifted = SUM_W'(area) << div_i_q;
	assign prod    = PROD_W'(row_off_q) * PROD_W'(geom.w);

	// distance back from the newest stored pixel, wrapped into the store
	assign diff    = {1'b0, base_q} - {1'b0, dist_q};
	assign rd_addr = diff[AW] ? AW'(diff + (AW + 1)'(STORE_DEPTH)) : diff[AW-1:0];
	assign next_row_dist = row_dist_q - AW'(geom.w);

	assign pop   = (state_q == ST_IDLE) && !q_empty;
	assign rd_en = (state_q == ST_READ);

	assign res.valid         = (state_q == ST_OUT);
	assign res.blurred_value = quo_q;
	assign res.last_of_frame = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			base_q     <= '0;
			sum_q      <= '0;
			quo_q      <= '0;
			div_i_q    <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			last_q     <= 1'b0;
			cy_q       <= '0;
			y1_q       <= '0;
			cx_q       <= '0;
			x0_q       <= '0;
			x1_q       <= '0;
			row_off_q  <= '0;
			col_off_q  <= '0;
			dist_q     <= '0;
			row_dist_q <= '0;
			rd_v_q     <= 1'b0;
		end else if (restart) begin
			state_q   <= ST_IDLE;
			out_col_q <= '0;
			out_row_q <= '0;
			rd_v_q    <= 1'b0;
		end else begin
			rd_v_q <= rd_en;
			if (rd_v_q) begin
				sum_q <= sum_q + SUM_W'(rd_data);
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						base_q    <= q_base;
						sum_q     <= SUM_W'(area >> 1);
						cy_q      <= out_row_q - ROW_W'(ry);
						y1_q      <= y1_n;
						cx_q      <= out_col_q - COL_W'(rx);
						x0_q      <= out_col_q - COL_W'(rx);
						x1_q      <= x1_n;
						row_off_q <= OFF_W'(geom.r) + OFF_W'(ry);
						col_off_q <= OFF_W'(geom.r) + OFF_W'(rx);
						last_q    <= (out_row_q == geom.h - 1'b1) &&
						             (out_col_q == geom.w - 1'b1);
						state_q   <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					dist_q     <= AW'(prod + PROD_W'(col_off_q));
					row_dist_q <= AW'(prod + PROD_W'(col_off_q));
					state_q    <= ST_READ;
				end
				ST_READ: begin
					if (cx_q == x1_q) begin
						if (cy_q == y1_q) begin
							state_q <= ST_WAIT;
						end else begin
							cy_q       <= cy_q + 1'b1;
							cx_q       <= x0_q;
							row_dist_q <= next_row_dist;
							dist_q     <= next_row_dist;
						end
					end else begin
						cx_q   <= cx_q + 1'b1;
						dist_q <= dist_q - 1'b1;
					end
				end
				ST_WAIT: begin
					div_i_q <= DIV_W'(QUO_W - 1);
					quo_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sum_q >= shifted) begin
						sum_q          <= sum_q - shifted;
						quo_q[div_i_q] <= 1'b1;
					end
					if (div_i_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						div_i_q <= div_i_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (res.ready) begin
						if (last_q) begin
							out_col_q <= '0;
							out_row_q <= '0;
						end else if (out_col_q == geom.w - 1'b1) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + 1'b1;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/bbz_checker.sv =====
`include "box_blur_zero_padded_unit_defines.svh"

module bbz_checker import bbz_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input logic [PIX_W-1:0] res_blurred_value,
	input logic             res_last_of_frame
);

	`BBZ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_blurred_value) && $stable(res_last_of_frame), "result changed while stalled")
	`BBZ_ASSERT_NOW(a_reset_quiet, !arst_n, !res_valid, "result shown during reset")
	`BBZ_ASSERT_NEXT(a_result_gap, res_valid && res_ready, !res_valid ##1 !res_valid, "results closer than the back end allows")

endmodule

bind box_blur_zero_padded_unit bbz_checker u_bbz_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_blurred_value (res.blurred_value),
	.res_last_of_frame (res.last_of_frame)
);
